FILE: rtl/core/mvtg_pkg.sv
`default_nettype none

package mvtg_pkg;

  localparam int unsigned SQUARE_VOICES_DEF   = 4;
  localparam int unsigned TRIANGLE_VOICES_DEF = 2;
  localparam int unsigned SAW_VOICES_DEF      = 2;

  // up to eight voices of each kind
  localparam int unsigned VOICE_IDX_W = 3;

  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned PERIOD_W = 15;
  localparam int unsigned MIX_W    = 8;
  localparam int unsigned TICK_W   = 16;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_PERIOD = 2'd1;
  localparam logic [1:0] OP_VOLUME = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_SQUARE   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_SAW      = 2'd2;

  localparam logic [PHASE_W-1:0] SQUARE_STEP = 16'd8;
  localparam logic [PHASE_W-1:0] SLOW_STEP   = 16'd64;

  localparam logic [3:0] VOLUME_MAX = 4'd15;
  localparam logic [7:0] TRI_UP     = 8'd2;
  localparam logic [7:0] TRI_DOWN   = 8'd254;
  localparam logic [7:0] TRI_TOP    = 8'd17;
  localparam logic [7:0] TRI_TOP_TO = 8'd14;
  localparam logic [7:0] TRI_BOT    = 8'd254;
  localparam logic [7:0] TRI_BOT_TO = 8'd1;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_STEP    = 3'd3,
    CMD_PUBLISH = 3'd4
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                op;
    logic [1:0]             kind;
    logic [VOICE_IDX_W-1:0] idx;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/mvtg_ctrl.sv
`default_nettype none

module mvtg_ctrl #(
  parameter int unsigned SQUARE_VOICES   = mvtg_pkg::SQUARE_VOICES_DEF,
  parameter int unsigned TRIANGLE_VOICES = mvtg_pkg::TRIANGLE_VOICES_DEF,
  parameter int unsigned SAW_VOICES      = mvtg_pkg::SAW_VOICES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire logic [1:0]    operation_i,
  output      logic          out_valid_o,
  input  wire logic          out_stall_i,
  output      mvtg_pkg::cmd_t cmd_o
);
  import mvtg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SQUARE   = 5'b00010,
    ST_TRIANGLE = 5'b00100,
    ST_SAW      = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_e;

  localparam logic [VOICE_IDX_W-1:0] SqLast  = VOICE_IDX_W'(SQUARE_VOICES - 1);
  localparam logic [VOICE_IDX_W-1:0] TriLast = VOICE_IDX_W'(TRIANGLE_VOICES - 1);
  localparam logic [VOICE_IDX_W-1:0] SawLast = VOICE_IDX_W'(SAW_VOICES - 1);

  state_e                 state_q, state_d;
  logic [VOICE_IDX_W-1:0] cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   accept;
  logic                   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = CMD_NONE;
    cmd_o.kind  = KIND_SQUARE;
    cmd_o.idx   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_TICK) begin
            cmd_o.op = CMD_TICK;
            cnt_d    = '0;
            state_d  = ST_SQUARE;
          end else begin
            cmd_o.op = CMD_WRITE;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.op   = CMD_STEP;
        cmd_o.kind = KIND_SQUARE;
        if (cnt_q == SqLast) begin
          cnt_d   = '0;
          state_d = ST_TRIANGLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_TRIANGLE: begin
        cmd_o.op   = CMD_STEP;
        cmd_o.kind = KIND_TRIANGLE;
        if (cnt_q == TriLast) begin
          cnt_d   = '0;
          state_d = ST_SAW;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SAW: begin
        cmd_o.op   = CMD_STEP;
        cmd_o.kind = KIND_SAW;
        if (cnt_q == SawLast) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.op    = CMD_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mvtg_datapath.sv
`default_nettype none

module mvtg_datapath #(
  parameter int unsigned SQUARE_VOICES   = mvtg_pkg::SQUARE_VOICES_DEF,
  parameter int unsigned TRIANGLE_VOICES = mvtg_pkg::TRIANGLE_VOICES_DEF,
  parameter int unsigned SAW_VOICES      = mvtg_pkg::SAW_VOICES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mvtg_pkg::cmd_t                    cmd_i,
  input  wire logic [1:0]                        operation_i,
  input  wire logic [1:0]                        voice_kind_i,
  input  wire logic [1:0]                        voice_index_i,
  input  wire logic [mvtg_pkg::PERIOD_W-1:0]     write_value_i,
  output      logic [mvtg_pkg::MIX_W-1:0]        mixed_level_o,
  output      logic [mvtg_pkg::TICK_W-1:0]       tick_count_o
);
  import mvtg_pkg::*;

  localparam int unsigned SqW  = (SQUARE_VOICES > 1) ? $clog2(SQUARE_VOICES) : 1;
  localparam int unsigned TriW = (TRIANGLE_VOICES > 1) ? $clog2(TRIANGLE_VOICES) : 1;
  localparam int unsigned SawW = (SAW_VOICES > 1) ? $clog2(SAW_VOICES) : 1;

  logic [PERIOD_W-1:0] sq_period_q  [SQUARE_VOICES];
  logic [PHASE_W-1:0]  sq_phase_q   [SQUARE_VOICES];
  logic [3:0]          sq_level_q   [SQUARE_VOICES];
  logic [3:0]          sq_volume_q  [SQUARE_VOICES];
  logic [PERIOD_W-1:0] tri_period_q [TRIANGLE_VOICES];
  logic [PHASE_W-1:0]  tri_phase_q  [TRIANGLE_VOICES];
  logic [7:0]          tri_level_q  [TRIANGLE_VOICES];
  logic                tri_rising_q [TRIANGLE_VOICES];
  logic [PERIOD_W-1:0] saw_period_q [SAW_VOICES];
  logic [PHASE_W-1:0]  saw_phase_q  [SAW_VOICES];
  logic [3:0]          saw_level_q  [SAW_VOICES];

  logic [TICK_W-1:0]   tick_q;
  logic [MIX_W-1:0]    mix_q;
  logic [MIX_W-1:0]    mixed_q;
  logic [TICK_W-1:0]   tick_out_q;

  logic [SqW-1:0]      sq_idx, sq_widx;
  logic [TriW-1:0]     tri_idx, tri_widx;
  logic [SawW-1:0]     saw_idx, saw_widx;
  logic                sq_hit, tri_hit, saw_hit;
  logic [3:0]          vol_sat;

  logic [PERIOD_W-1:0] sel_period;
  logic [PHASE_W-1:0]  sel_phase;
  logic [PHASE_W-1:0]  sel_step;
  logic [PHASE_W-1:0]  phase_sub;
  logic [PHASE_W-1:0]  phase_new;
  logic                wrapped;

  logic [3:0]          sq_level_new;
  logic [7:0]          tri_sum;
  logic [7:0]          tri_level_new;
  logic                tri_rising_new;
  logic [3:0]          saw_level_new;
  logic [7:0]          level_add;

  assign sq_idx   = SqW'(cmd_i.idx);
  assign tri_idx  = TriW'(cmd_i.idx);
  assign saw_idx  = SawW'(cmd_i.idx);
  assign sq_widx  = SqW'(voice_index_i);
  assign tri_widx = TriW'(voice_index_i);
  assign saw_widx = SawW'(voice_index_i);

  assign sq_hit  = (voice_kind_i == KIND_SQUARE) && (32'(voice_index_i) < SQUARE_VOICES);
  assign tri_hit = (voice_kind_i == KIND_TRIANGLE) &&
                   (32'(voice_index_i) < TRIANGLE_VOICES);
  assign saw_hit = (voice_kind_i == KIND_SAW) && (32'(voice_index_i) < SAW_VOICES);
  assign vol_sat = (|write_value_i[PERIOD_W-1:4]) ? VOLUME_MAX : write_value_i[3:0];

  // shared phase unit, one voice a cycle
  always_comb begin
    sel_period = '0;
    sel_phase  = '0;
    sel_step   = SLOW_STEP;
    case (cmd_i.kind)
      KIND_SQUARE: begin
        sel_period = sq_period_q[sq_idx];
        sel_phase  = sq_phase_q[sq_idx];
        sel_step   = SQUARE_STEP;
      end
      KIND_TRIANGLE: begin
        sel_period = tri_period_q[tri_idx];
        sel_phase  = tri_phase_q[tri_idx];
      end
      KIND_SAW: begin
        sel_period = saw_period_q[saw_idx];
        sel_phase  = saw_phase_q[saw_idx];
      end
      default: begin
        sel_period = '0;
      end
    endcase
    phase_sub = sel_phase - sel_step;
    wrapped   = (sel_period != '0) && phase_sub[PHASE_W-1];
    if (sel_period == '0) begin
      phase_new = sel_phase;
    end else if (wrapped) begin
      phase_new = phase_sub + PHASE_W'(sel_period);
    end else begin
      phase_new = phase_sub;
    end
  end

  always_comb begin
    sq_level_new = sq_level_q[sq_idx];
    if (wrapped) begin
      sq_level_new = (sq_level_q[sq_idx] != '0) ? 4'd0 : sq_volume_q[sq_idx];
    end
    tri_sum        = tri_level_q[tri_idx] + (tri_rising_q[tri_idx] ? TRI_UP : TRI_DOWN);
    tri_level_new  = tri_level_q[tri_idx];
    tri_rising_new = tri_rising_q[tri_idx];
    if (wrapped) begin
      if (tri_sum == TRI_TOP) begin
        tri_level_new  = TRI_TOP_TO;
        tri_rising_new = 1'b0;
      end else if (tri_sum == TRI_BOT) begin
        tri_level_new  = TRI_BOT_TO;
        tri_rising_new = 1'b1;
      end else begin
        tri_level_new = tri_sum;
      end
    end
    saw_level_new = wrapped ? saw_level_q[saw_idx] + 4'd1 : saw_level_q[saw_idx];
    case (cmd_i.kind)
      KIND_SQUARE:   level_add = 8'(sq_level_new);
      KIND_TRIANGLE: level_add = tri_level_new;
      KIND_SAW:      level_add = 8'(saw_level_new);
      default:       level_add = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SQUARE_VOICES; i++) begin
        sq_period_q[i] <= '0;
        sq_phase_q[i]  <= '0;
        sq_level_q[i]  <= '0;
        sq_volume_q[i] <= VOLUME_MAX;
      end
      for (int i = 0; i < TRIANGLE_VOICES; i++) begin
        tri_period_q[i] <= '0;
        tri_phase_q[i]  <= '0;
        tri_level_q[i]  <= '0;
        tri_rising_q[i] <= 1'b0;
      end
      for (int i = 0; i < SAW_VOICES; i++) begin
        saw_period_q[i] <= '0;
        saw_phase_q[i]  <= '0;
        saw_level_q[i]  <= '0;
      end
      tick_q <= '0;
      mix_q  <= '0;
    end else begin
      case (cmd_i.op)
        CMD_WRITE: begin
          if (sq_hit) begin
            if (operation_i == OP_PERIOD) begin
              sq_period_q[sq_widx] <= write_value_i;
            end else if (operation_i == OP_VOLUME) begin
              sq_volume_q[sq_widx] <= vol_sat;
            end else if (operation_i == OP_CLEAR) begin
              sq_period_q[sq_widx] <= '0;
              sq_phase_q[sq_widx]  <= '0;
              sq_level_q[sq_widx]  <= '0;
              sq_volume_q[sq_widx] <= VOLUME_MAX;
            end
          end else if (tri_hit) begin
            if (operation_i == OP_PERIOD) begin
              tri_period_q[tri_widx] <= write_value_i;
            end else if (operation_i == OP_CLEAR) begin
              tri_period_q[tri_widx] <= '0;
              tri_phase_q[tri_widx]  <= '0;
              tri_level_q[tri_widx]  <= '0;
              tri_rising_q[tri_widx] <= 1'b0;
            end
          end else if (saw_hit) begin
            if (operation_i == OP_PERIOD) begin
              saw_period_q[saw_widx] <= write_value_i;
            end else if (operation_i == OP_CLEAR) begin
              saw_period_q[saw_widx] <= '0;
              saw_phase_q[saw_widx]  <= '0;
              saw_level_q[saw_widx]  <= '0;
            end
          end
        end
        CMD_TICK: begin
          tick_q <= tick_q + 1'b1;
          mix_q  <= '0;
        end
        CMD_STEP: begin
          mix_q <= mix_q + level_add;
          case (cmd_i.kind)
            KIND_SQUARE: begin
              sq_phase_q[sq_idx] <= phase_new;
              sq_level_q[sq_idx] <= sq_level_new;
            end
            KIND_TRIANGLE: begin
              tri_phase_q[tri_idx]  <= phase_new;
              tri_level_q[tri_idx]  <= tri_level_new;
              tri_rising_q[tri_idx] <= tri_rising_new;
            end
            KIND_SAW: begin
              saw_phase_q[saw_idx] <= phase_new;
              saw_level_q[saw_idx] <= saw_level_new;
            end
            default: begin
            end
          endcase
        end
        default: begin
          mix_q <= mix_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_PUBLISH) begin
      mixed_q    <= mix_q;
      tick_out_q <= tick_q;
    end
  end

  assign mixed_level_o = mixed_q;
  assign tick_count_o  = tick_out_q;

endmodule

`default_nettype wire

FILE: rtl/core/multi_voice_tone_generator.sv
// a tick is accepted in idle; the single shared phase unit then visits one voice a cycle,
// every square, then every triangle, then every saw voice, and the finish state publishes
// the sum, waiting while the output register still holds a result not yet taken; writes
// and clears give no result, and no new request is taken until the tick has published
// reset: asynchronous active low; periods, phases and levels zero, volumes fifteen,
// triangles falling, tick counter zero
`default_nettype none

module multi_voice_tone_generator #(
  parameter int unsigned SQUARE_VOICES   = mvtg_pkg::SQUARE_VOICES_DEF,
  parameter int unsigned TRIANGLE_VOICES = mvtg_pkg::TRIANGLE_VOICES_DEF,
  parameter int unsigned SAW_VOICES      = mvtg_pkg::SAW_VOICES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [1:0]                    voice_kind_i,
  input  wire logic [1:0]                    voice_index_i,
  input  wire logic [mvtg_pkg::PERIOD_W-1:0] write_value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [mvtg_pkg::MIX_W-1:0]    mixed_level_o,
  output      logic [mvtg_pkg::TICK_W-1:0]   tick_count_o
);
  import mvtg_pkg::*;

  cmd_t cmd;

  mvtg_ctrl #(
    .SQUARE_VOICES   (SQUARE_VOICES),
    .TRIANGLE_VOICES (TRIANGLE_VOICES),
    .SAW_VOICES      (SAW_VOICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mvtg_datapath #(
    .SQUARE_VOICES   (SQUARE_VOICES),
    .TRIANGLE_VOICES (TRIANGLE_VOICES),
    .SAW_VOICES      (SAW_VOICES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .voice_kind_i  (voice_kind_i),
    .voice_index_i (voice_index_i),
    .write_value_i (write_value_i),
    .mixed_level_o (mixed_level_o),
    .tick_count_o  (tick_count_o)
  );

endmodule

`default_nettype wire

FILE: tb/tone_mix_checker.sv
module tone_mix_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [1:0]                    voice_kind_i,
  input  wire logic [1:0]                    voice_index_i,
  input  wire logic [mvtg_pkg::PERIOD_W-1:0] write_value_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [mvtg_pkg::MIX_W-1:0]    mixed_level_i,
  input  wire logic [mvtg_pkg::TICK_W-1:0]   tick_count_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mvtg_pkg::*;

  localparam int unsigned NSQ  = SQUARE_VOICES_DEF;
  localparam int unsigned NTRI = TRIANGLE_VOICES_DEF;
  localparam int unsigned NSAW = SAW_VOICES_DEF;

  typedef struct packed {
    logic [MIX_W-1:0]  mix;
    logic [TICK_W-1:0] ticks;
  } tone_sample_t;

  tone_sample_t expected_samples[$];

  logic [PERIOD_W-1:0] sq_period  [NSQ];
  logic [PHASE_W-1:0]  sq_phase   [NSQ];
  logic [3:0]          sq_level   [NSQ];
  logic [3:0]          sq_volume  [NSQ];
  logic [PERIOD_W-1:0] tri_period [NTRI];
  logic [PHASE_W-1:0]  tri_phase  [NTRI];
  logic [7:0]          tri_level  [NTRI];
  logic                tri_rising [NTRI];
  logic [PERIOD_W-1:0] saw_period [NSAW];
  logic [PHASE_W-1:0]  saw_phase  [NSAW];
  logic [3:0]          saw_level  [NSAW];
  logic [TICK_W-1:0]   tick_total;
  int                  mismatches;

  // top bit set when the phase went below zero and the period was added back
  function automatic logic [PHASE_W:0] next_phase(input logic [PHASE_W-1:0] phase,
                                                  input logic [PERIOD_W-1:0] period,
                                                  input logic [PHASE_W-1:0] step);
    logic [PHASE_W-1:0] p;
    p = phase - step;
    if (p[PHASE_W-1]) begin
      return {1'b1, p + PHASE_W'(period)};
    end
    return {1'b0, p};
  endfunction

  task automatic clear_square(input int i);
    sq_period[i] = '0;
    sq_phase[i]  = '0;
    sq_level[i]  = '0;
    sq_volume[i] = VOLUME_MAX;
  endtask

  task automatic clear_triangle(input int i);
    tri_period[i] = '0;
    tri_phase[i]  = '0;
    tri_level[i]  = '0;
    tri_rising[i] = 1'b0;
  endtask

  task automatic clear_saw(input int i);
    saw_period[i] = '0;
    saw_phase[i]  = '0;
    saw_level[i]  = '0;
  endtask

  task automatic apply_write(input logic [1:0] op, input logic [1:0] kind,
                             input logic [1:0] idx, input logic [PERIOD_W-1:0] value);
    int i;
    i = int'(idx);
    if (kind == KIND_SQUARE && i < NSQ) begin
      case (op)
        OP_PERIOD: sq_period[i] = value;
        OP_VOLUME: sq_volume[i] = (value > PERIOD_W'(VOLUME_MAX)) ? VOLUME_MAX : value[3:0];
        OP_CLEAR:  clear_square(i);
        default: ;
      endcase
    end else if (kind == KIND_TRIANGLE && i < NTRI) begin
      if (op == OP_PERIOD) begin
        tri_period[i] = value;
      end else if (op == OP_CLEAR) begin
        clear_triangle(i);
      end
    end else if (kind == KIND_SAW && i < NSAW) begin
      if (op == OP_PERIOD) begin
        saw_period[i] = value;
      end else if (op == OP_CLEAR) begin
        clear_saw(i);
      end
    end
  endtask

  function automatic tone_sample_t advance_voices();
    tone_sample_t s;
    logic [PHASE_W:0] np;
    logic [7:0] lvl;
    logic [MIX_W-1:0] mix;
    mix = '0;
    tick_total = tick_total + 1'b1;
    for (int i = 0; i < NSQ; i++) begin
      if (sq_period[i] != 0) begin
        np = next_phase(sq_phase[i], sq_period[i], SQUARE_STEP);
        sq_phase[i] = np[PHASE_W-1:0];
        if (np[PHASE_W]) begin
          sq_level[i] = (sq_level[i] != 0) ? 4'd0 : sq_volume[i];
        end
      end
      mix = mix + MIX_W'(sq_level[i]);
    end
    for (int i = 0; i < NTRI; i++) begin
      if (tri_period[i] != 0) begin
        np = next_phase(tri_phase[i], tri_period[i], SLOW_STEP);
        tri_phase[i] = np[PHASE_W-1:0];
        if (np[PHASE_W]) begin
          lvl = tri_level[i] + (tri_rising[i] ? TRI_UP : TRI_DOWN);
          if (lvl == TRI_TOP) begin
            lvl = TRI_TOP_TO;
            tri_rising[i] = 1'b0;
          end else if (lvl == TRI_BOT) begin
            lvl = TRI_BOT_TO;
            tri_rising[i] = 1'b1;
          end
          tri_level[i] = lvl;
        end
      end
      mix = mix + MIX_W'(tri_level[i]);
    end
    for (int i = 0; i < NSAW; i++) begin
      if (saw_period[i] != 0) begin
        np = next_phase(saw_phase[i], saw_period[i], SLOW_STEP);
        saw_phase[i] = np[PHASE_W-1:0];
        if (np[PHASE_W]) begin
          saw_level[i] = saw_level[i] + 4'd1;
        end
      end
      mix = mix + MIX_W'(saw_level[i]);
    end
    s.mix   = mix;
    s.ticks = tick_total;
    return s;
  endfunction

  task automatic check_sample();
    tone_sample_t want;
    if (expected_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result with none pending: mix %0d ticks %0d",
                 $time, mixed_level_i, tick_count_i);
      end
    end else begin
      want = expected_samples.pop_front();
      if (want.mix != mixed_level_i || want.ticks != tick_count_i) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mix exp %0d got %0d, ticks exp %0d got %0d", $time,
                   want.mix, mixed_level_i, want.ticks, tick_count_i);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSQ; i++) clear_square(i);
      for (int i = 0; i < NTRI; i++) clear_triangle(i);
      for (int i = 0; i < NSAW; i++) clear_saw(i);
      tick_total = '0;
      mismatches = 0;
      expected_samples.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_sample();
      end
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_TICK) begin
          expected_samples.push_back(advance_voices());
        end else begin
          apply_write(operation_i, voice_kind_i, voice_index_i, write_value_i);
        end
      end
      fail_count_o <= mismatches;
      pending_o <= expected_samples.size();
    end
  end

endmodule

FILE: tb/multi_voice_tone_generator_test.sv
module multi_voice_tone_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mvtg_pkg::*;

  localparam int RUN_LIMIT = 400_000;
  localparam int PHASE_ITEMS = 345;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          operation;
  logic [1:0]          voice_kind;
  logic [1:0]          voice_index;
  logic [PERIOD_W-1:0] write_value;
  logic                out_valid;
  logic                out_stall;
  logic [MIX_W-1:0]    mixed_level;
  logic [TICK_W-1:0]   tick_count;

  int sender_idle_pct = 14;
  int receiver_stall_pct = 85;
  int cycle_count = 0;
  int mismatch_total;
  int samples_pending;

  multi_voice_tone_generator u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .voice_kind_i  (voice_kind),
    .voice_index_i (voice_index),
    .write_value_i (write_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .mixed_level_o (mixed_level),
    .tick_count_o  (tick_count)
  );

  tone_mix_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .operation_i   (operation),
    .voice_kind_i  (voice_kind),
    .voice_index_i (voice_index),
    .write_value_i (write_value),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .mixed_level_i (mixed_level),
    .tick_count_i  (tick_count),
    .fail_count_o  (mismatch_total),
    .pending_o     (samples_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [1:0] kind,
                              input logic [1:0] idx, input logic [PERIOD_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    voice_kind  <= kind;
    voice_index <= idx;
    write_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_tick();
    send_request(OP_TICK, 2'($urandom_range(3)), 2'($urandom_range(3)),
                 PERIOD_W'($urandom_range(32767)));
  endtask

  task automatic wait_for_samples();
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_pending != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    int unsigned roll;
    int unsigned pick;
    logic [1:0] kind;
    logic [PERIOD_W-1:0] value;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    kind = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(2));
    if (roll < 60) begin
      send_tick();
    end else if (roll < 82) begin
      // mostly short periods so the levels move often
      if (pick < 70) begin
        value = PERIOD_W'($urandom_range(160, 1));
      end else if (pick < 85) begin
        value = PERIOD_W'($urandom_range(2000, 161));
      end else if (pick < 95) begin
        value = PERIOD_W'($urandom_range(32767));
      end else begin
        value = '0;
      end
      send_request(OP_PERIOD, kind, 2'($urandom_range(3)), value);
    end else if (roll < 93) begin
      value = (pick < 75) ? PERIOD_W'($urandom_range(15)) : PERIOD_W'($urandom_range(32767));
      send_request(OP_VOLUME, kind, 2'($urandom_range(3)), value);
    end else begin
      send_request(OP_CLEAR, kind, 2'($urandom_range(3)), PERIOD_W'($urandom_range(32767)));
    end
  endtask

  initial begin
    in_valid    <= 1'b0;
    operation   <= OP_TICK;
    voice_kind  <= KIND_SQUARE;
    voice_index <= 2'd0;
    write_value <= '0;
    out_stall   <= 1'b0;
    rst_n       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // silent voices first, then extremes of period and volume
    send_request(OP_TICK, 2'd3, 2'd3, '1);
    send_request(OP_PERIOD, KIND_SQUARE, 2'd0, 15'd1);
    send_request(OP_PERIOD, KIND_SQUARE, 2'd3, 15'd32767);
    send_request(OP_VOLUME, KIND_SQUARE, 2'd1, 15'd32767);
    send_request(OP_PERIOD, KIND_SQUARE, 2'd1, 15'd9);
    send_request(OP_VOLUME, KIND_SQUARE, 2'd2, 15'd0);
    send_request(OP_PERIOD, KIND_SQUARE, 2'd2, 15'd16);
    // volume only applies to squares
    send_request(OP_VOLUME, KIND_TRIANGLE, 2'd0, 15'd5);
    send_request(OP_VOLUME, KIND_SAW, 2'd1, 15'd7);
    send_request(OP_PERIOD, KIND_TRIANGLE, 2'd0, 15'd1);
    send_request(OP_PERIOD, KIND_TRIANGLE, 2'd1, 15'd64);
    send_request(OP_PERIOD, KIND_SAW, 2'd0, 15'd63);
    send_request(OP_PERIOD, KIND_SAW, 2'd1, 15'd32767);
    // unknown kind and out of range indexes do nothing
    send_request(OP_PERIOD, 2'd3, 2'd0, 15'd100);
    send_request(OP_PERIOD, KIND_TRIANGLE, 2'd3, 15'd5);
    send_request(OP_CLEAR, KIND_SAW, 2'd2, '0);
    repeat (3) send_tick();
    send_request(OP_CLEAR, KIND_SQUARE, 2'd0, '0);
    send_request(OP_CLEAR, KIND_TRIANGLE, 2'd0, '0);
    send_request(OP_CLEAR, KIND_SAW, 2'd1, '0);
    send_request(OP_PERIOD, KIND_SQUARE, 2'd2, '0);
    send_request(OP_VOLUME, KIND_SQUARE, 2'd3, 15'd16);
    send_tick();
    wait_for_samples();

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        sender_idle_pct = 85;
        receiver_stall_pct <= 14;
      end else if (p == 2) begin
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
      end
      repeat (PHASE_ITEMS) send_random_request();
      wait_for_samples();
    end

    repeat (24) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
